// ----- rtl/core/bsd_pkg.sv -----
// Shared types and constants for the backend slot dispatcher.
// Request and result structs, action and register codes, reset values.
// No dependencies.
package bsd_pkg;

   localparam int NUM_BACKENDS = 3;
   localparam int ADDR_W       = 32;
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 8;
   localparam int LEVEL_W      = 9;

   // decoupling queue between classifier and executor
   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_W = 1;
   localparam int FQ_CNT_W = 2;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   localparam logic [ADDR_W-1:0]  CLIENT_RESET   = 32'd16781740;
   localparam logic [ADDR_W-1:0]  BACKEND0_RESET = 32'd33558956;
   localparam logic [ADDR_W-1:0]  BACKEND1_RESET = 32'd50336172;
   localparam logic [ADDR_W-1:0]  BACKEND2_RESET = 32'd67113388;
   localparam logic [COUNT_W-1:0] LIMIT_RESET    = 8'd5;

   typedef enum logic [2:0] {
      ACT_FORWARD    = 3'd0,
      ACT_QUEUED     = 3'd1,
      ACT_DROP       = 3'd2,
      ACT_PASS       = 3'd3,
      ACT_NO_PENDING = 3'd4,
      ACT_NO_FREE    = 3'd5
   } act_type;

   typedef enum logic [2:0] {
      CSR_CLIENT   = 3'd0,
      CSR_BACKEND0 = 3'd1,
      CSR_BACKEND1 = 3'd2,
      CSR_BACKEND2 = 3'd3,
      CSR_LIMIT    = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_PASS   = 2'd0,
      KIND_CLIENT = 2'd1,
      KIND_REPLY  = 2'd2
   } kind_type;

   typedef struct packed {
      logic              eligible;
      logic [ADDR_W-1:0] source_addr;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      act_type            action;
      logic [1:0]         backend_index;
      logic [ADDR_W-1:0]  dest_addr;
      logic [DATA_W-1:0]  payload_out;
      logic [LEVEL_W-1:0] queue_level;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]                   client_addr;
      logic [NUM_BACKENDS-1:0][ADDR_W-1:0] backend_addr;
      logic [COUNT_W-1:0]                  slot_limit;
   } cfg_type;

   // classified request as held in the decoupling queue
   typedef struct packed {
      kind_type          kind;
      logic [1:0]        reply_idx;
      logic [DATA_W-1:0] payload;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } fe_type;

endpackage

// ----- rtl/core/bsd_front.sv -----
// Front end: classifies each accepted request by source and eligibility
// and holds it in a two-entry queue for the executor. Uses bsd_pkg.
module bsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsd_pkg::req_type req_data,
   output logic             full,
   input  bsd_pkg::cfg_type cfg,
   output bsd_pkg::fe_type  fe_out,
   input  logic             take
);

   bsd_pkg::item_type              fq_ff [bsd_pkg::FQ_DEPTH];
   logic [bsd_pkg::FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bsd_pkg::FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bsd_pkg::FQ_CNT_W-1:0]   cnt_ff, cnt_in;
   bsd_pkg::item_type              cls;
   logic                           do_push;
   logic                           do_pop;

   // client match wins over a backend match; lowest backend index wins
   always_comb begin
      cls.kind      = bsd_pkg::KIND_PASS;
      cls.reply_idx = 2'd0;
      cls.payload   = req_data.payload;
      if (req_data.eligible) begin
         if (req_data.source_addr == cfg.client_addr) begin
            cls.kind = bsd_pkg::KIND_CLIENT;
         end else if (req_data.source_addr == cfg.backend_addr[0]) begin
            cls.kind = bsd_pkg::KIND_REPLY;
         end else if (req_data.source_addr == cfg.backend_addr[1]) begin
            cls.kind      = bsd_pkg::KIND_REPLY;
            cls.reply_idx = 2'd1;
         end else if (req_data.source_addr == cfg.backend_addr[2]) begin
            cls.kind      = bsd_pkg::KIND_REPLY;
            cls.reply_idx = 2'd2;
         end
      end
   end

   assign full    = (cnt_ff == bsd_pkg::FQ_CNT_W'(bsd_pkg::FQ_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = take && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fq_ff[wr_ptr_ff] <= cls;
      end
   end

   assign fe_out.valid = (cnt_ff != '0);
   assign fe_out.item  = fq_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/bsd_back.sv -----
// Executor: busy counts, wait queue store and the dispatch decision,
// with a registered result stage. Uses bsd_pkg.
module bsd_back #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bsd_pkg::cfg_type                cfg,
   input  bsd_pkg::fe_type                 fe_in,
   output logic                            take,
   input  logic [bsd_pkg::RSP_CNT_W-1:0]   out_level,
   output logic                            out_push,
   output bsd_pkg::rsp_type                out_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

   logic [bsd_pkg::NUM_BACKENDS-1:0][bsd_pkg::COUNT_W-1:0] busy_ff, busy_in;
   logic [bsd_pkg::NUM_BACKENDS-1:0][bsd_pkg::COUNT_W-1:0] busy_dec;
   logic [bsd_pkg::NUM_BACKENDS-1:0]                       free;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic [CNT_W-1:0]            wcnt_ff, wcnt_in;
   logic [bsd_pkg::DATA_W-1:0]  store_ff [QUEUE_DEPTH];
   logic [bsd_pkg::DATA_W-1:0]  rd_data_ff;
   logic                        w_valid_ff;
   bsd_pkg::rsp_type            w_res_ff, res;
   logic                        w_from_store_ff;
   logic                        push_store;
   logic                        pop_store;
   logic                        any_free;
   logic [1:0]                  pick;
   logic                        inc;
   logic [bsd_pkg::ADDR_W-1:0]  pick_addr;
   bsd_pkg::item_type           it;

   assign it = fe_in.item;

   // credit: the result stage and result queue together never overflow
   assign take = fe_in.valid &&
                 ((out_level + bsd_pkg::RSP_CNT_W'(w_valid_ff))
                  < bsd_pkg::RSP_CNT_W'(bsd_pkg::RSP_DEPTH));

   // a reply frees its slot before the free search
   always_comb begin
      for (int i = 0; i < bsd_pkg::NUM_BACKENDS; i++) begin
         busy_dec[i] = busy_ff[i];
         if (it.kind == bsd_pkg::KIND_REPLY && it.reply_idx == 2'(i)
             && busy_ff[i] != '0) begin
            busy_dec[i] = busy_ff[i] - 1'b1;
         end
         free[i] = (busy_dec[i] < cfg.slot_limit);
      end
   end

   always_comb begin
      any_free = |free;
      if (free[0]) begin
         pick = 2'd0;
      end else if (free[1]) begin
         pick = 2'd1;
      end else begin
         pick = 2'd2;
      end
   end

   always_comb begin
      unique case (pick)
         2'd0:    pick_addr = cfg.backend_addr[0];
         2'd1:    pick_addr = cfg.backend_addr[1];
         default: pick_addr = cfg.backend_addr[2];
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      wcnt_in    = wcnt_ff;
      push_store = 1'b0;
      pop_store  = 1'b0;
      inc        = 1'b0;
      res.action        = bsd_pkg::ACT_PASS;
      res.backend_index = 2'd0;
      res.dest_addr     = '0;
      res.payload_out   = '0;
      if (take) begin
         case (it.kind)
            bsd_pkg::KIND_CLIENT: begin
               if (any_free) begin
                  inc             = 1'b1;
                  res.action      = bsd_pkg::ACT_FORWARD;
                  res.payload_out = it.payload;
               end else if (wcnt_ff != CNT_FULL) begin
                  push_store = 1'b1;
                  tail_in    = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                  wcnt_in    = wcnt_ff + 1'b1;
                  res.action = bsd_pkg::ACT_QUEUED;
               end else begin
                  res.action = bsd_pkg::ACT_DROP;
               end
            end
            bsd_pkg::KIND_REPLY: begin
               busy_in = busy_dec;
               if (wcnt_ff == '0) begin
                  res.action = bsd_pkg::ACT_NO_PENDING;
               end else if (!any_free) begin
                  res.action = bsd_pkg::ACT_NO_FREE;
               end else begin
                  // payload comes from the store read in the next stage
                  pop_store  = 1'b1;
                  inc        = 1'b1;
                  head_in    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
                  wcnt_in    = wcnt_ff - 1'b1;
                  res.action = bsd_pkg::ACT_FORWARD;
               end
            end
            default: ;
         endcase
         if (inc) begin
            res.backend_index = pick;
            res.dest_addr     = pick_addr;
            for (int i = 0; i < bsd_pkg::NUM_BACKENDS; i++) begin
               if (pick == 2'(i)) begin
                  busy_in[i] = busy_dec[i] + 1'b1;
               end
            end
         end
      end
      res.queue_level = bsd_pkg::LEVEL_W'(wcnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         wcnt_ff    <= '0;
         w_valid_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         wcnt_ff    <= wcnt_in;
         w_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (push_store) begin
         store_ff[tail_ff] <= it.payload;
      end
      if (pop_store) begin
         rd_data_ff <= store_ff[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         w_res_ff        <= res;
         w_from_store_ff <= pop_store;
      end
   end

   always_comb begin
      out_data = w_res_ff;
      if (w_from_store_ff) begin
         out_data.payload_out = rd_data_ff;
      end
   end

   assign out_push = w_valid_ff;

`ifndef ASSERT_OFF
   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= CNT_FULL)
      else $error("wait count above queue depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (wcnt_ff == '0 || wcnt_ff == CNT_FULL))
      else $error("wait pointers disagree with count");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (w_valid_ff && w_res_ff.action != bsd_pkg::ACT_FORWARD)
      |-> (w_res_ff.backend_index == 2'd0 && w_res_ff.dest_addr == '0
           && !w_from_store_ff))
      else $error("non-forward result carries dispatch fields");
`endif

endmodule

// ----- rtl/core/bsd_rsp_fifo.sv -----
// Result queue: a short FIFO that parts the executor from the receiver.
// Reports its fill level back as credit. Uses bsd_pkg.
module bsd_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_push,
   input  bsd_pkg::rsp_type              in_data,
   output logic [bsd_pkg::RSP_CNT_W-1:0] level,
   output logic                          empty,
   input  logic                          pop,
   output bsd_pkg::rsp_type              rsp_data
);

   bsd_pkg::rsp_type                mem_ff [bsd_pkg::RSP_DEPTH];
   logic [bsd_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bsd_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bsd_pkg::RSP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            do_pop;

   assign empty  = (cnt_ff == '0);
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = in_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (in_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !in_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   assign level    = cnt_ff;
   assign rsp_data = mem_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_push |-> (cnt_ff < bsd_pkg::RSP_CNT_W'(bsd_pkg::RSP_DEPTH) || do_pop))
      else $error("result queue written while full");
`endif

endmodule

// ----- rtl/core/backend_slot_dispatcher_with_wait_queue_top.sv -----
// Top level of the backend slot dispatcher: configuration registers and the
// front, executor and result queue. Uses bsd_pkg, bsd_front, bsd_back, bsd_rsp_fifo.
//
// Usage
//   Requests enter through push/full with req_data; one result per request
//   leaves through empty/pop with rsp_data, in request order.
//   Configuration: csr_we, csr_index, csr_wdata; index 0 client address,
//   1..3 backend addresses, 4 slot limit (low 8 bits). Write only while idle.
// Timing
//   A request pushed passes the front queue, then the dispatch decision with
//   wait-store read into the result register, then the result queue.
//   One request per cycle sustained while pop keeps the result queue draining;
//   the dispatch step updates busy counts and the wait-store pointers every
//   cycle, and the store has one write and one registered read port.
// Reset
//   Busy counts, wait pointers and queues clear; registers take their defaults.
//   The wait store is not cleared and no clearing pass runs.
// Stall
//   While pop is held low the four-entry result queue fills, dispatch stops,
//   the two-entry front queue fills and full rises. Nothing is lost.
module backend_slot_dispatcher_with_wait_queue_top #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  bsd_pkg::req_type            req_data,
   output logic                        empty,
   input  logic                        pop,
   output bsd_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [bsd_pkg::ADDR_W-1:0]  csr_wdata
);

   bsd_pkg::cfg_type                cfg_ff, cfg_in;
   bsd_pkg::fe_type                 fe;
   logic                            take;
   logic [bsd_pkg::RSP_CNT_W-1:0]   out_level;
   logic                            out_push;
   bsd_pkg::rsp_type                out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (bsd_pkg::csr_idx_type'(csr_index))
            bsd_pkg::CSR_CLIENT:   cfg_in.client_addr     = csr_wdata;
            bsd_pkg::CSR_BACKEND0: cfg_in.backend_addr[0] = csr_wdata;
            bsd_pkg::CSR_BACKEND1: cfg_in.backend_addr[1] = csr_wdata;
            bsd_pkg::CSR_BACKEND2: cfg_in.backend_addr[2] = csr_wdata;
            bsd_pkg::CSR_LIMIT:    cfg_in.slot_limit      = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.client_addr     <= bsd_pkg::CLIENT_RESET;
         cfg_ff.backend_addr[0] <= bsd_pkg::BACKEND0_RESET;
         cfg_ff.backend_addr[1] <= bsd_pkg::BACKEND1_RESET;
         cfg_ff.backend_addr[2] <= bsd_pkg::BACKEND2_RESET;
         cfg_ff.slot_limit      <= bsd_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cfg      (cfg_ff),
      .fe_out   (fe),
      .take     (take)
   );

   bsd_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fe_in     (fe),
      .take      (take),
      .out_level (out_level),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   bsd_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .in_push  (out_push),
      .in_data  (out_data),
      .level    (out_level),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
